// ----- design/fppm_pkg.sv -----
// ----------------------------------------------------------------------------
// fppm_pkg: shared types and constants
// Register indexes, residual range and the depth of the job queue used by the
// fixed polynomial predictor with mid/side stereo.
// ----------------------------------------------------------------------------
`default_nettype none

package fppm_pkg;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_ORDER  = 1'b0,
    REG_STEREO = 1'b1
  } reg_idx_t;

  localparam int RES_BITS = 19;
  localparam int RES_MAX  = 262143;
  localparam int RES_MIN  = -262144;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

// ----- design/fppm_front.sv -----
// ----------------------------------------------------------------------------
// fppm_front: sample intake and stereo pairing
// Accepts samples, holds the left sample of a stereo pair and forms mid and
// side on the right one, then queues one job per mono sample or stereo pair.
// ----------------------------------------------------------------------------
`default_nettype none

module fppm_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            stereo_mode,
  input  wire                            stereo_write,
  input  wire                            accept,
  input  wire signed [SAMPLE_BITS-1:0]   sample,
  output logic                           job_push,
  output logic       [2*SAMPLE_BITS:0]   job_data
);

  logic                          right_expected;
  logic signed [SAMPLE_BITS-1:0] held_left;
  logic signed [SAMPLE_BITS:0]   sum;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [SAMPLE_BITS:0]   sum_adj;
  logic signed [SAMPLE_BITS:0]   diff_adj;
  logic signed [SAMPLE_BITS-1:0] mid;
  logic signed [SAMPLE_BITS-1:0] side;

  // Halving toward zero: add one to a negative value before the shift.
  always_comb begin
    sum      = {held_left[SAMPLE_BITS-1], held_left} + {sample[SAMPLE_BITS-1], sample};
    diff     = {held_left[SAMPLE_BITS-1], held_left} - {sample[SAMPLE_BITS-1], sample};
    sum_adj  = sum + (SAMPLE_BITS+1)'(sum[SAMPLE_BITS]);
    diff_adj = diff + (SAMPLE_BITS+1)'(diff[SAMPLE_BITS]);
    mid      = sum_adj[SAMPLE_BITS:1];
    side     = diff_adj[SAMPLE_BITS:1];
  end

  // A job carries {pair, side, main}; a mono job leaves side unused.
  always_comb begin
    job_push = 1'b0;
    job_data = {1'b0, {SAMPLE_BITS{1'b0}}, sample};
    if (accept) begin
      if (!stereo_mode) begin
        job_push = 1'b1;
      end else if (right_expected) begin
        job_push = 1'b1;
        job_data = {1'b1, side, mid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_expected <= 1'b0;
      held_left      <= '0;
    end else if (stereo_write) begin
      right_expected <= 1'b0;
    end else if (accept && stereo_mode) begin
      right_expected <= !right_expected;
      if (!right_expected) begin
        held_left <= sample;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fppm_queue.sv -----
// ----------------------------------------------------------------------------
// fppm_queue: job queue between intake and predictor
// A small first-in first-out buffer that lets intake and predictor stall
// independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module fppm_queue
  import fppm_pkg::*;
#(
  parameter int WIDTH = 33
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr_en,
  input  wire [WIDTH-1:0]  wr_data,
  input  wire              rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty,
  output logic             is_full
);

  logic [WIDTH-1:0]  entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign rd_data   = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign is_full   = (count == (PTR_BITS+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fppm_back.sv -----
// ----------------------------------------------------------------------------
// fppm_back: polynomial predictor and result register
// Takes jobs from the queue, predicts from the channel history, saturates the
// residual and holds it in the result register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fppm_back
  import fppm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [1:0]                 predictor_order,
  input  wire                        job_valid,
  input  wire  [2*SAMPLE_BITS:0]     job_data,
  output logic                       job_pop,
  input  wire                        pop,
  output logic                       out_valid,
  output logic signed [RES_BITS-1:0] residual,
  output logic                       channel_kind,
  output logic                       last
);

  localparam int EW = (SAMPLE_BITS + 4 > RES_BITS + 1) ? SAMPLE_BITS + 4 : RES_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] main_hist [3];
  logic signed [SAMPLE_BITS-1:0] side_hist [3];
  logic                          phase;
  logic                          advance;
  logic                          fire;
  logic                          job_pair;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [EW-1:0]          xe;
  logic signed [EW-1:0]          h0;
  logic signed [EW-1:0]          h1;
  logic signed [EW-1:0]          h2;
  logic signed [EW-1:0]          r;
  logic signed [EW-1:0]          res_max;
  logic signed [EW-1:0]          res_min;
  logic signed [RES_BITS-1:0]    r_sat;

  assign job_pair = job_data[2*SAMPLE_BITS];
  assign advance  = !out_valid || pop;
  assign fire     = advance && job_valid;
  // A stereo job stays at the head of the queue until its side residual is out.
  assign job_pop  = fire && (!job_pair || phase);

  always_comb begin
    res_max = EW'(RES_MAX);
    res_min = EW'(RES_MIN);
    if (phase) begin
      x  = job_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
      h0 = EW'(side_hist[0]);
      h1 = EW'(side_hist[1]);
      h2 = EW'(side_hist[2]);
    end else begin
      x  = job_data[SAMPLE_BITS-1:0];
      h0 = EW'(main_hist[0]);
      h1 = EW'(main_hist[1]);
      h2 = EW'(main_hist[2]);
    end
    xe = EW'(x);
    unique case (predictor_order)
      2'd0: r = xe;
      2'd1: r = xe - h0;
      2'd2: r = xe - (h0 <<< 1) + h1;
      2'd3: r = xe - ((h0 <<< 1) + h0) + ((h1 <<< 1) + h1) - h2;
    endcase
    priority if (r > res_max) begin
      r_sat = res_max[RES_BITS-1:0];
    end else if (r < res_min) begin
      r_sat = res_min[RES_BITS-1:0];
    end else begin
      r_sat = r[RES_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else if (fire) begin
      phase     <= job_pair && !phase;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      residual     <= r_sat;
      channel_kind <= phase;
      last         <= !job_pair || phase;
    end
  end

  // Histories shift on every update of their channel, whatever the order.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_hist <= '{default: '0};
      side_hist <= '{default: '0};
    end else if (fire) begin
      if (phase) begin
        side_hist[2] <= side_hist[1];
        side_hist[1] <= side_hist[0];
        side_hist[0] <= x;
      end else begin
        main_hist[2] <= main_hist[1];
        main_hist[1] <= main_hist[0];
        main_hist[0] <= x;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fixed_poly_predictor_midside_unit.sv -----
// ----------------------------------------------------------------------------
// fixed_poly_predictor_midside_unit: fixed polynomial predictor, mid/side
// Top level with configuration registers, intake, job queue and predictor.
// ----------------------------------------------------------------------------
// The unit takes one sample per clock while the job queue is not full and
// returns residuals of a fixed polynomial predictor of order 0 to 3. In mono
// mode each sample gives one residual, so the sustained rate is one sample per
// cycle. In stereo mode a left sample is only held; the right one gives a mid
// and then a side residual. The predictor stage, which produces one residual
// per cycle while its results are taken, limits this rate. The first result of
// a request passes through the job queue and then the result register before
// it is on the result ports, and a side residual follows its mid residual in
// the cycle after the mid one is taken. A four-entry job queue absorbs short
// stalls on the result side. Configuration registers: predictor_order at
// address 0, stereo_mode at address 4.
`default_nettype none

module fixed_poly_predictor_midside_unit
  import fppm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [2:0]                 paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  wire                        push,
  output logic                       full,
  input  wire  [SAMPLE_BITS-1:0]     sample,
  input  wire                        pop,
  output logic                       empty,
  output logic signed [RES_BITS-1:0] residual,
  output logic                       channel_kind,
  output logic                       last
);

  localparam int JOB_BITS = 2 * SAMPLE_BITS + 1;

  logic [1:0]          predictor_order;
  logic                stereo_mode;
  logic                cfg_write;
  logic                stereo_write;
  reg_idx_t            reg_idx;
  logic                accept;
  logic                job_push;
  logic [JOB_BITS-1:0] job_wdata;
  logic [JOB_BITS-1:0] job_rdata;
  logic                job_valid;
  logic                job_pop;
  logic                out_valid;

  assign pready       = 1'b1;
  assign reg_idx      = reg_idx_t'(paddr[2]);
  assign cfg_write    = psel && penable && pwrite && pready;
  assign stereo_write = cfg_write && (reg_idx == REG_STEREO);
  assign accept       = push && !full;
  assign empty        = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_order <= '0;
      stereo_mode     <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_ORDER:  predictor_order <= pwdata[1:0];
        REG_STEREO: stereo_mode     <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORDER:  prdata = {30'd0, predictor_order};
      REG_STEREO: prdata = {31'd0, stereo_mode};
    endcase
  end

  fppm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .stereo_mode (stereo_mode),
    .stereo_write(stereo_write),
    .accept      (accept),
    .sample      (sample),
    .job_push    (job_push),
    .job_data    (job_wdata)
  );

  fppm_queue #(
    .WIDTH(JOB_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_data  (job_wdata),
    .rd_en    (job_pop),
    .rd_data  (job_rdata),
    .not_empty(job_valid),
    .is_full  (full)
  );

  fppm_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .predictor_order(predictor_order),
    .job_valid      (job_valid),
    .job_data       (job_rdata),
    .job_pop        (job_pop),
    .pop            (pop),
    .out_valid      (out_valid),
    .residual       (residual),
    .channel_kind   (channel_kind),
    .last           (last)
  );

endmodule

`default_nettype wire

// ----- design/fppm_checker.sv -----
// ----------------------------------------------------------------------------
// fppm_checker: port-level checks for the predictor unit
// Watches the result queue ports and the pairing of mid and side results.
// ----------------------------------------------------------------------------
`default_nettype none

module fppm_checker (
  input wire clk,
  input wire rst,
  input wire full,
  input wire pop,
  input wire empty,
  input wire channel_kind,
  input wire last
);

  // Both queues come out of reset empty.
  assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A waiting result holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(channel_kind) && $stable(last))
    else $error("waiting result changed before it was taken");

  // A side residual always closes its sample's results.
  assert property (@(posedge clk) disable iff (rst)
    !empty && channel_kind |-> last)
    else $error("side residual not marked last");

  // A mid residual is followed right away by its side residual.
  assert property (@(posedge clk) disable iff (rst)
    !empty && !last && pop |=> !empty && channel_kind)
    else $error("mid residual not followed by side residual");

endmodule

bind fixed_poly_predictor_midside_unit fppm_checker u_fppm_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .pop         (pop),
  .empty       (empty),
  .channel_kind(channel_kind),
  .last        (last)
);

`default_nettype wire

// ----- tb/sv/fixed_poly_predictor_midside_unit_test.sv -----
// ----------------------------------------------------------------------------
// fixed_poly_predictor_midside_unit_test: residual checker for the predictor
// Feeds PCM samples in mono and stereo mode under every predictor order and
// compares each residual, channel kind and last flag with an in-bench model.
// ----------------------------------------------------------------------------
module fixed_poly_predictor_midside_unit_test;
  import fppm_pkg::*;

  localparam logic [1:0] ORDER_RAW    = 2'd0;
  localparam logic [1:0] ORDER_FIRST  = 2'd1;
  localparam logic [1:0] ORDER_SECOND = 2'd2;
  localparam logic [1:0] ORDER_THIRD  = 2'd3;
  localparam bit MODE_MONO   = 1'b0;
  localparam bit MODE_STEREO = 1'b1;
  localparam bit KIND_MAIN = 1'b0;
  localparam bit KIND_SIDE = 1'b1;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL = 80;

  typedef struct {
    logic signed [RES_BITS-1:0] residual;
    bit kind;
    bit last_flag;
  } residual_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic [15:0] sample = '0;
  logic pop = 1'b0;
  logic empty;
  logic signed [RES_BITS-1:0] residual;
  logic channel_kind;
  logic last;

  // Copy of the block's configuration and channel state.
  logic [1:0] pred_order = ORDER_RAW;
  bit stereo_on = MODE_MONO;
  bit want_right = 1'b0;
  int left_hold = 0;
  int chan_hist[2][3] = '{default: 0};

  logic [15:0] sample_q[$];
  residual_t residual_q[$];
  int errors = 0;
  int last_gen = 0;
  bit no_idle = 1'b0;
  bit send_hold = 1'b0;
  bit long_stall_go = 1'b0;
  int stall_cnt = 0;

  fixed_poly_predictor_midside_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .sample(sample),
    .pop(pop), .empty(empty),
    .residual(residual), .channel_kind(channel_kind), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [RES_BITS-1:0] channel_residual(bit ch, int x);
    longint h0, h1, h2, r;
    h0 = chan_hist[ch][0];
    h1 = chan_hist[ch][1];
    h2 = chan_hist[ch][2];
    case (pred_order)
      ORDER_RAW:    r = x;
      ORDER_FIRST:  r = x - h0;
      ORDER_SECOND: r = x - 2 * h0 + h1;
      default:      r = x - 3 * h0 + 3 * h1 - h2;
    endcase
    // The history always shifts, whatever the order.
    chan_hist[ch][2] = chan_hist[ch][1];
    chan_hist[ch][1] = chan_hist[ch][0];
    chan_hist[ch][0] = x;
    if (r > RES_MAX) r = RES_MAX;
    if (r < RES_MIN) r = RES_MIN;
    return r[RES_BITS-1:0];
  endfunction

  task automatic predict_sample(logic [15:0] s);
    int x, mid_v, side_v;
    residual_t res;
    x = int'($signed(s));
    if (stereo_on == MODE_MONO) begin
      res.residual = channel_residual(KIND_MAIN, x);
      res.kind = KIND_MAIN;
      res.last_flag = 1'b1;
      residual_q.push_back(res);
    end else if (!want_right) begin
      left_hold = x;
      want_right = 1'b1;
    end else begin
      want_right = 1'b0;
      // Integer division truncates toward zero, as the block does.
      mid_v = (left_hold + x) / 2;
      side_v = (left_hold - x) / 2;
      res.residual = channel_residual(KIND_MAIN, mid_v);
      res.kind = KIND_MAIN;
      res.last_flag = 1'b0;
      residual_q.push_back(res);
      res.residual = channel_residual(KIND_SIDE, side_v);
      res.kind = KIND_SIDE;
      res.last_flag = 1'b1;
      residual_q.push_back(res);
    end
  endtask

  // Request side: an offered sample stays on the port until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_sample(sample);
      if (push && full) begin
        push <= 1'b1;
      end else if (sample_q.size() != 0 && !send_hold &&
                   (no_idle || $urandom_range(99) >= 23)) begin
        push <= 1'b1;
        sample <= sample_q.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result side.
  always @(posedge clk) begin
    residual_t exp_res;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (residual_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got residual %0d kind %0d last %0d",
                   $time, residual, channel_kind, last);
          errors++;
        end else begin
          exp_res = residual_q.pop_front();
          if (residual !== exp_res.residual) begin
            $display("%0t: residual mismatch: expected %0d, got %0d",
                     $time, exp_res.residual, residual);
            errors++;
          end
          if (channel_kind !== exp_res.kind) begin
            $display("%0t: channel_kind mismatch: expected %0d, got %0d",
                     $time, exp_res.kind, channel_kind);
            errors++;
          end
          if (last !== exp_res.last_flag) begin
            $display("%0t: last mismatch: expected %0d, got %0d",
                     $time, exp_res.last_flag, last);
            errors++;
          end
        end
      end
      if (long_stall_go && stall_cnt < LONG_STALL) begin
        stall_cnt <= stall_cnt + 1;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || $urandom_range(99) >= 23;
      end
    end
  end

  task automatic wait_results();
    while (sample_q.size() != 0 || push || residual_q.size() != 0) @(posedge clk);
  endtask

  // A left sample gives no result, so allow the pipeline to settle as well.
  task automatic drain();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ORDER) begin
      pred_order = value[1:0];
    end else begin
      stereo_on = value[0];
      want_right = 1'b0;
    end
  endtask

  task automatic set_config(logic [1:0] order, bit mode, bit force_mode);
    drain();
    write_reg(REG_ORDER, ($urandom & ~32'h3) | order);
    if (force_mode || mode != stereo_on || $urandom_range(1))
      write_reg(REG_STEREO, ($urandom & ~32'h1) | mode);
  endtask

  function automatic logic [15:0] gen_sample();
    int pick, v;
    logic [15:0] raw;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // Smooth signal, the kind a predictor is built for.
      v = last_gen + int'($urandom_range(512)) - 256;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else if (pick < 85) begin
      raw = 16'($urandom);
      v = int'($signed(raw));
    end else begin
      case ($urandom_range(3))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        default: v = -1;
      endcase
    end
    last_gen = v;
    return v[15:0];
  endfunction

  initial begin
    int n_items;
    logic [1:0] order;
    bit mode;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every order, the zero start of history,
    // truncation toward zero and a mode write while a left sample is held.
    set_config(ORDER_RAW, MODE_MONO, 1'b1);
    sample_q = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001};
    set_config(ORDER_THIRD, MODE_MONO, 1'b0);
    sample_q = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
    set_config(ORDER_SECOND, MODE_STEREO, 1'b1);
    sample_q = '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                 16'hffff, 16'h0000, 16'h0003, 16'hfffe, 16'd1234};
    set_config(ORDER_FIRST, MODE_STEREO, 1'b1);
    sample_q = '{16'd100, 16'hff9c};

    for (int p = 0; p < 13; p++) begin
      order = (p < 4) ? p[1:0] : 2'($urandom_range(3));
      mode = (p < 8) ? p[0] : bit'($urandom_range(1));
      set_config(order, mode, 1'b0);
      n_items = $urandom_range(90, 126);
      if (p == 7) no_idle = 1'b1;
      if (p == 8) no_idle = 1'b0;
      if (p == 5) begin
        for (int i = 0; i < n_items / 2; i++) sample_q.push_back(gen_sample());
        wait_results();
        n_items = n_items - n_items / 2;
      end
      for (int i = 0; i < n_items; i++) sample_q.push_back(gen_sample());
      if (p == 3) long_stall_go = 1'b1;
    end

    drain();
    if (errors == 0) begin
      $display("** fixed_poly_predictor_midside_unit: PASSED **");
    end else begin
      $display("** fixed_poly_predictor_midside_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** fixed_poly_predictor_midside_unit: FAILED **");
    $finish;
  end

endmodule
